[sv/ibf_pkg.sv]
// Shared constants and types for the 3x3 box filter.
`default_nettype none

package ibf_pkg;

  // Frame limits and field widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int WEIGHT_W   = 16;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 12;
  localparam int PROD_W     = SUM_W + WEIGHT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_WEIGHT       = 2'd2
  } cfg_reg_t;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd10;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd50;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd7209;
  localparam logic [PIX_W-1:0]    PIX_MAX    = 8'd255;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // One input item as it moves down the pipe and through the result queue
  typedef struct packed {
    logic             filt;   // filtered result for (row-1, col-1) pending
    logic             bord;   // border pass-through for (row, col) pending
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] fval;
    logic [PIX_W-1:0] pix;
  } res_item_t;

endpackage

`default_nettype wire

[sv/image_box_filter_3x3.sv]
// 3x3 box filter over a raster pixel stream: line store, window, multiply, result queue.
`default_nettype none

// Channel   Ports                                               Direction
// ---------------------------------------------------------------------------
// config    cfg_we, cfg_index[1:0], cfg_data[15:0]              in (write only)
// input     in_valid, in_stall, in_pixel[7:0]                   in  (stall out)
// result    out_valid, out_stall, out_row[11:0], out_col[9:0],  out (stall in)
//           out_value[7:0], out_is_border, out_last_of_run
//
// One pixel item is taken per clock while in_stall is low. Its first result
// reaches the port after the line store read, window sum, multiply and queue.
// Pixels on the last row or last column at row >= 2, col >= 2 give two results,
// which leave the port one after the other; a long run of them (the last row)
// drains slower than items come in, and in_stall rises when the eight-item
// result queue cannot take what is still in the pipe. Reset is synchronous,
// clears counters, window, pipe and queue; the line store has no clearing pass.

module image_box_filter_3x3 (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // config
  input  wire logic                           cfg_we,
  input  wire logic [ibf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ibf_pkg::CFG_DATA_W-1:0] cfg_data,
  // input pixels
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ibf_pkg::PIX_W-1:0]      in_pixel,
  // results
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ibf_pkg::ROW_W-1:0]           out_row,
  output logic [ibf_pkg::COL_W-1:0]           out_col,
  output logic [ibf_pkg::PIX_W-1:0]           out_value,
  output logic                                out_is_border,
  output logic                                out_last_of_run
);

  // ------------------------------------------------------------------
  // Config registers, clamped frame size
  // ------------------------------------------------------------------
  logic [ibf_pkg::WIDTH_W-1:0]  width_r;
  logic [ibf_pkg::HEIGHT_W-1:0] height_r;
  logic [ibf_pkg::WEIGHT_W-1:0] weight_r;
  logic [ibf_pkg::WIDTH_W-1:0]  eff_w;
  logic [ibf_pkg::HEIGHT_W-1:0] eff_h;
  logic                         dim_wr;

  always_comb begin
    if (width_r == '0) begin
      eff_w = 11'd1;
    end else if (width_r > 11'(ibf_pkg::MAX_WIDTH)) begin
      eff_w = 11'(ibf_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = 13'd1;
    end else if (height_r > 13'(ibf_pkg::MAX_HEIGHT)) begin
      eff_h = 13'(ibf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // a size write starts a new frame
  assign dim_wr = cfg_we && ((cfg_index == ibf_pkg::CFG_IMAGE_WIDTH) ||
                             (cfg_index == ibf_pkg::CFG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ibf_pkg::WIDTH_RST;
      height_r <= ibf_pkg::HEIGHT_RST;
      weight_r <= ibf_pkg::WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ibf_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[ibf_pkg::WIDTH_W-1:0];
        ibf_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data[ibf_pkg::HEIGHT_W-1:0];
        ibf_pkg::CFG_WEIGHT:       weight_r <= cfg_data[ibf_pkg::WEIGHT_W-1:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage 0: position counters, line store read
  // ------------------------------------------------------------------
  logic [ibf_pkg::ROW_W-1:0]    row_r, row_nxt, cur_r;
  logic [ibf_pkg::COL_W-1:0]    col_r, col_nxt, cur_c;
  logic [ibf_pkg::WIDTH_W-1:0]  col_inc;
  logic [ibf_pkg::HEIGHT_W-1:0] row_inc;
  logic                         wrap, in_acc;
  ibf_pkg::res_item_t           s0_item;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    // stale position after a size change folds back to the frame start
    wrap  = ({1'b0, col_r} >= eff_w) || ({1'b0, row_r} >= eff_h);
    cur_c = wrap ? '0 : col_r;
    cur_r = wrap ? '0 : row_r;
    col_inc = {1'b0, cur_c} + 11'd1;
    row_inc = {1'b0, cur_r} + 13'd1;

    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_h) ? '0 : row_inc[ibf_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[ibf_pkg::COL_W-1:0];
      row_nxt = cur_r;
    end

    s0_item.filt = (cur_r >= 12'd2) && (cur_c >= 10'd2);
    s0_item.bord = (cur_r == '0) || ({1'b0, cur_r} == eff_h - 13'd1) ||
                   (cur_c == '0) || ({1'b0, cur_c} == eff_w - 11'd1);
    s0_item.row  = cur_r;
    s0_item.col  = cur_c;
    s0_item.fval = '0;
    s0_item.pix  = in_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (dim_wr) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Line store: {upper, lower} per column. Read on accept, written back in the
  // next cycle. Same-column accesses are at least width items apart, and
  // width >= 3 whenever the stored values reach a result.
  logic [2*ibf_pkg::PIX_W-1:0] lmem [ibf_pkg::MAX_WIDTH];
  logic [2*ibf_pkg::PIX_W-1:0] lmem_q;
  logic                        s1_valid_r;
  ibf_pkg::res_item_t          s1_item_r;
  logic [ibf_pkg::PIX_W-1:0]   top, mid;

  always_ff @(posedge clk) begin
    lmem_q <= lmem[cur_c];
    if (s1_valid_r) begin
      lmem[s1_item_r.col] <= {mid, s1_item_r.pix};
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: window and 3x3 sum
  // ------------------------------------------------------------------
  logic [ibf_pkg::PIX_W-1:0]   win_r [6];   // c-1 top/mid/bot, c-2 top/mid/bot
  logic [ibf_pkg::SUM_W-1:0]   sum;

  assign top = lmem_q[2*ibf_pkg::PIX_W-1:ibf_pkg::PIX_W];
  assign mid = lmem_q[ibf_pkg::PIX_W-1:0];

  always_comb begin
    sum = {4'b0, top} + {4'b0, mid} + {4'b0, s1_item_r.pix};
    for (int i = 0; i < 6; i++) begin
      sum = sum + {4'b0, win_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= in_acc;
      if (s1_valid_r) begin
        win_r[3] <= win_r[0];
        win_r[4] <= win_r[1];
        win_r[5] <= win_r[2];
        win_r[0] <= top;
        win_r[1] <= mid;
        win_r[2] <= s1_item_r.pix;
      end
    end
    s1_item_r <= s0_item;
  end

  // ------------------------------------------------------------------
  // Stage 2: multiply by weight; stage 3: truncate, saturate, enqueue
  // ------------------------------------------------------------------
  logic                        s2_valid_r, s3_valid_r;
  ibf_pkg::res_item_t          s2_item_r, s3_item_r, s3_out;
  logic [ibf_pkg::SUM_W-1:0]   s2_sum_r;
  logic [ibf_pkg::PROD_W-1:0]  s3_prod_r;
  logic                        push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
    s2_item_r <= s1_item_r;
    s2_sum_r  <= sum;
    s3_item_r <= s2_item_r;
    s3_prod_r <= s2_sum_r * weight_r;
  end

  always_comb begin
    s3_out = s3_item_r;
    if (s3_prod_r[ibf_pkg::PROD_W-1:ibf_pkg::WEIGHT_W] > 12'(ibf_pkg::PIX_MAX)) begin
      s3_out.fval = ibf_pkg::PIX_MAX;
    end else begin
      s3_out.fval = s3_prod_r[ibf_pkg::WEIGHT_W+ibf_pkg::PIX_W-1:ibf_pkg::WEIGHT_W];
    end
  end

  // items with no result are dropped here
  assign push = s3_valid_r && (s3_item_r.filt || s3_item_r.bord);

  // ------------------------------------------------------------------
  // Result queue and output holding register
  // ------------------------------------------------------------------
  ibf_pkg::res_item_t          fifo_mem [ibf_pkg::FIFO_DEPTH];
  logic [ibf_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ibf_pkg::FIFO_CW-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [ibf_pkg::FIFO_CW:0]   reserved;
  ibf_pkg::res_item_t          hd_r;
  logic                        hd_valid_r, out_acc, hd_free, pop, two_left;

  // every item in the pipe holds a queue slot in reserve
  assign reserved = {1'b0, fifo_cnt_r} + 5'(s1_valid_r) + 5'(s2_valid_r) +
                    5'(s3_valid_r);
  assign in_stall = reserved >= 5'(ibf_pkg::FIFO_DEPTH);

  assign two_left = hd_r.filt && hd_r.bord;
  assign out_acc  = hd_valid_r && !out_stall;
  assign hd_free  = !hd_valid_r || (out_acc && !two_left);
  assign pop      = hd_free && (fifo_cnt_r != '0);

  assign fifo_cnt_nxt = fifo_cnt_r + 4'(push) - 4'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= s3_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      hd_valid_r <= 1'b0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 3'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 3'd1;
      end
      if (hd_free) begin
        hd_valid_r <= pop;
      end
    end
    // filtered result leaves first, border pass-through stays behind
    if (out_acc && two_left) begin
      hd_r.filt <= 1'b0;
    end else if (pop) begin
      hd_r <= fifo_mem[rd_ptr_r];
    end
  end

  assign out_valid       = hd_valid_r;
  assign out_row         = hd_r.filt ? hd_r.row - 12'd1 : hd_r.row;
  assign out_col         = hd_r.filt ? hd_r.col - 10'd1 : hd_r.col;
  assign out_value       = hd_r.filt ? hd_r.fval : hd_r.pix;
  assign out_is_border   = !hd_r.filt;
  assign out_last_of_run = !two_left;

endmodule

`default_nettype wire

[sv/ibf_checker.sv]
// Port-level checks for the 3x3 box filter, bound to the top level.
`default_nettype none

module ibf_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [ibf_pkg::ROW_W-1:0]      out_row,
  input wire logic [ibf_pkg::COL_W-1:0]      out_col,
  input wire logic [ibf_pkg::PIX_W-1:0]      out_value,
  input wire logic                           out_is_border,
  input wire logic                           out_last_of_run
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_row, out_col, out_value, out_is_border, out_last_of_run}))
    else $error("result changed while stalled");

  // reset empties the pipe and queue
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // only a filtered result can be followed by another one from the same item
  a_first_filtered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !out_is_border)
    else $error("border result not last of its run");

  // a taken non-last result is followed at once by the border result
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      out_valid && out_is_border && out_last_of_run)
    else $error("second result of a pair missing");

  // filtered pixels are never on the first row or column
  a_filt_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_border |-> out_row != '0 && out_col != '0)
    else $error("filtered result on the border");

endmodule

bind image_box_filter_3x3 ibf_checker u_ibf_checker (.*);

`default_nettype wire
